@@ src/sro_pkg.sv @@
package sro_pkg;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_RELEASE  = 2'd2;

    // Configuration reset values.
    localparam logic [6:0]  CAPACITY_RST = 7'd50;
    localparam logic [15:0] TIMEOUT_RST  = 16'd500;
    localparam logic [6:0]  RELEASE_RST  = 7'd10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] seq_in;
        logic [31:0] stamp_in;
        logic [31:0] handle_in;
    } in_item_t;

    typedef struct packed {
        logic        chunk_valid;
        logic [31:0] seq_out;
        logic [31:0] stamp_out;
        logic [31:0] handle_out;
        logic        last;
        logic [6:0]  occupancy;
        logic [31:0] expected_next;
        logic [31:0] received_count;
        logic [31:0] reordered_count;
        logic [31:0] dropped_count;
    } out_item_t;

    // One stored chunk; mark flags a chunk chosen for in-order release.
    typedef struct packed {
        logic        valid;
        logic        mark;
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [31:0] handle;
    } entry_t;

endpackage

@@ src/sro_cell.sv @@
module sro_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  logic            clr_all,
    input  sro_pkg::entry_t d,
    output sro_pkg::entry_t q
);
    import sro_pkg::*;

    logic        valid_reg;
    logic        mark_reg;
    logic [31:0] seq_reg;
    logic [31:0] stamp_reg;
    logic [31:0] handle_reg;

    // Flags: cleared by reset or a clear command, else loaded from the neighbor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else if (clr_all) begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= d.valid;
            mark_reg  <= d.mark;
        end
    end

    // Chunk payload moves with the flags.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            seq_reg    <= d.seq;
            stamp_reg  <= d.stamp;
            handle_reg <= d.handle;
        end
    end

    assign q = '{valid: valid_reg, mark: mark_reg, seq: seq_reg,
                 stamp: stamp_reg, handle: handle_reg};

endmodule

@@ src/sequence_reorder_buffer.sv @@
// Channel   Direction  Ports                         Content
// input     in         s_valid s_ready s_data        command and chunk
// result    out        m_valid m_ready m_data        chunk or status, last flag
// config    in         cfg_valid cfg_ready cfg_index register write
//                      cfg_data
//
// Entries sit in a ring of DEPTH cells that rotates one place per cycle while a scan runs;
// the controller works on the entry at the head, and every scan is one full rotation.
// An add takes 2 or 3 scans (eviction search when full, match, placement with timeout), a
// release search, and for n released chunks n+1 further scans. A flush of k entries takes
// k+1 scans. Reset is synchronous and empties the ring; a stalled result halts it at the
// next chunk.
module sequence_reorder_buffer #(
    parameter int DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sro_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sro_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import sro_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(DEPTH - 1);
    localparam logic [PW-1:0] FULL_MISS = PW'(DEPTH);
    localparam logic [PW-1:0] PASS_STEP = PW'(1);
    localparam logic [6:0]    DEPTH7    = 7'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EVICT   = 8'b0000_0010,
        S_INSERT  = 8'b0000_0100,
        S_PLACE   = 8'b0000_1000,
        S_MARK    = 8'b0001_0000,
        S_MINFIND = 8'b0010_0000,
        S_EMIT    = 8'b0100_0000,
        S_STATUS  = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    in_item_t    in_reg, in_next;
    logic [6:0]  cap_reg, lim_reg;
    logic [15:0] tmo_reg;
    logic [6:0]  occ_reg, occ_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] reo_reg, reo_next;
    logic [31:0] drp_reg, drp_next;
    logic [PW-1:0] pass_reg, pass_next;
    logic        best_vld_reg, best_vld_next;
    logic [31:0] best_a_reg, best_a_next;
    logic [31:0] best_b_reg, best_b_next;
    logic [31:0] max_reg, max_next;
    logic        found_reg, found_next;
    logic        placed_reg, placed_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  ntot_reg, ntot_next;
    logic        flush_reg, flush_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] cur_reg, cur_next;
    out_item_t   out_reg, out_next;
    logic        m_valid_reg, m_valid_next;

    entry_t      cell_q [DEPTH];
    entry_t      head, wb;
    logic        shift_en, clr_all;
    logic        out_free;
    logic [6:0]  cap_eff, lim_eff;
    logic [31:0] key, age;
    logic        place_new, tmo_hit, cand;

    // Ring of cells: each cell loads from its upper neighbor, the last from the written-back head.
    for (genvar i = 0; i < DEPTH; i++) begin : g_ring
        entry_t d_i;
        if (i == DEPTH - 1) begin : g_tail
            assign d_i = wb;
        end else begin : g_mid
            assign d_i = cell_q[i+1];
        end
        sro_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .clr_all  (clr_all),
            .d        (d_i),
            .q        (cell_q[i])
        );
    end

    assign head = cell_q[0];

    // Effective limits after clamping.
    assign cap_eff = (cap_reg == 7'd0) ? 7'd1 : ((cap_reg > DEPTH7) ? DEPTH7 : cap_reg);
    assign lim_eff = (lim_reg > DEPTH7) ? DEPTH7 : lim_reg;

    // Head values shared by the scans.
    assign place_new = (state_reg == S_PLACE) && !head.valid && !placed_reg;
    assign age       = now_reg - (place_new ? in_reg.stamp_in : head.stamp);
    assign tmo_hit   = !age[31] && (age > {16'd0, tmo_reg});
    assign key       = head.seq - base_reg;
    assign cand      = head.valid && (flush_reg || head.mark);
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // Controller.
    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        occ_next      = occ_reg;
        exp_next      = exp_reg;
        now_next      = now_reg;
        rcv_next      = rcv_reg;
        reo_next      = reo_reg;
        drp_next      = drp_reg;
        pass_next     = pass_reg;
        best_vld_next = best_vld_reg;
        best_a_next   = best_a_reg;
        best_b_next   = best_b_reg;
        max_next      = max_reg;
        found_next    = found_reg;
        placed_next   = placed_reg;
        cnt_next      = cnt_reg;
        ntot_next     = ntot_reg;
        flush_next    = flush_reg;
        base_next     = base_reg;
        cur_next      = cur_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        shift_en      = 1'b0;
        clr_all       = 1'b0;
        wb            = head;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next       = s_data;
                    pass_next     = '0;
                    best_vld_next = 1'b0;
                    case (s_data.cmd)
                        CMD_ADD: begin
                            rcv_next   = rcv_reg + 32'd1;
                            found_next = 1'b0;
                            if (s_data.seq_in != exp_reg) begin
                                reo_next = reo_reg + 32'd1;
                            end
                            state_next = (occ_reg >= cap_eff) ? S_EVICT : S_INSERT;
                        end
                        CMD_TICK: begin
                            now_next   = now_reg + 32'd1;
                            state_next = S_STATUS;
                        end
                        CMD_FLUSH: begin
                            flush_next = 1'b1;
                            base_next  = '0;
                            state_next = (occ_reg == 7'd0) ? S_STATUS : S_MINFIND;
                        end
                        default: begin
                            clr_all    = 1'b1;
                            exp_next   = '0;
                            occ_next   = '0;
                            state_next = S_STATUS;
                        end
                    endcase
                end
            end

            // Find the oldest entry: smallest stamp, then lowest sequence.
            S_EVICT: begin
                shift_en = 1'b1;
                if (head.valid && (!best_vld_reg || head.stamp < best_a_reg ||
                    (head.stamp == best_a_reg && head.seq < best_b_reg))) begin
                    best_vld_next = 1'b1;
                    best_a_next   = head.stamp;
                    best_b_next   = head.seq;
                end
                pass_next = pass_reg + PASS_STEP;
                if (pass_reg == LAST_POS) begin
                    pass_next  = '0;
                    state_next = S_INSERT;
                end
            end

            // Drop the victim and overwrite a held chunk of the same sequence.
            S_INSERT: begin
                shift_en = 1'b1;
                if (head.valid && best_vld_reg && head.seq == best_b_reg) begin
                    wb.valid = 1'b0;
                    wb.mark  = 1'b0;
                    drp_next = drp_reg + 32'd1;
                    occ_next = occ_reg - 7'd1;
                end else if (head.valid && head.seq == in_reg.seq_in) begin
                    wb.stamp   = in_reg.stamp_in;
                    wb.handle  = in_reg.handle_in;
                    found_next = 1'b1;
                end
                pass_next = pass_reg + PASS_STEP;
                if (pass_reg == LAST_POS) begin
                    pass_next   = '0;
                    placed_next = found_next;
                    state_next  = S_PLACE;
                end
            end

            // Place a new chunk in the first free cell and age out stale entries.
            S_PLACE: begin
                shift_en = 1'b1;
                if (place_new) begin
                    wb          = '{valid: 1'b1, mark: 1'b0, seq: in_reg.seq_in,
                                    stamp: in_reg.stamp_in, handle: in_reg.handle_in};
                    placed_next = 1'b1;
                end
                if (wb.valid && tmo_hit) begin
                    wb.valid = 1'b0;
                    drp_next = drp_reg + 32'd1;
                    if (!place_new) begin
                        occ_next = occ_reg - 7'd1;
                    end
                end else if (place_new) begin
                    occ_next = occ_reg + 7'd1;
                end
                pass_next = pass_reg + PASS_STEP;
                if (pass_reg == LAST_POS) begin
                    pass_next  = '0;
                    cnt_next   = '0;
                    base_next  = exp_reg;
                    flush_next = 1'b0;
                    state_next = S_MARK;
                end
            end

            // Mark consecutive chunks for release until the release limit is reached or a full rotation finds none.
            S_MARK: begin
                if (cnt_reg == lim_eff || pass_reg == FULL_MISS) begin
                    ntot_next     = cnt_reg;
                    best_vld_next = 1'b0;
                    pass_next     = '0;
                    state_next    = (cnt_reg == 7'd0) ? S_STATUS : S_MINFIND;
                end else begin
                    shift_en = 1'b1;
                    if (head.valid && !head.mark && head.seq == exp_reg) begin
                        wb.mark   = 1'b1;
                        exp_next  = exp_reg + 32'd1;
                        cnt_next  = cnt_reg + 7'd1;
                        occ_next  = occ_reg - 7'd1;
                        pass_next = '0;
                    end else begin
                        pass_next = pass_reg + PASS_STEP;
                    end
                end
            end

            // Smallest key among candidates; also tracks the highest sequence, which a flush uses.
            S_MINFIND: begin
                shift_en = 1'b1;
                if (cand && (!best_vld_reg || key < best_a_reg)) begin
                    best_a_next = key;
                end
                if (cand && (!best_vld_reg || head.seq > max_reg)) begin
                    max_next = head.seq;
                end
                if (cand) begin
                    best_vld_next = 1'b1;
                end
                pass_next = pass_reg + PASS_STEP;
                if (pass_reg == LAST_POS) begin
                    pass_next     = '0;
                    cur_next      = best_a_next;
                    best_vld_next = 1'b0;
                    cnt_next      = '0;
                    if (flush_reg) begin
                        exp_next  = max_next + 32'd1;
                        ntot_next = occ_reg;
                        occ_next  = '0;
                    end
                    state_next = S_EMIT;
                end
            end

            // Emit the current key and look for the next one in the same rotation.
            S_EMIT: begin
                if (cand && key == cur_reg) begin
                    if (out_free) begin
                        shift_en     = 1'b1;
                        m_valid_next = 1'b1;
                        out_next     = '{chunk_valid: 1'b1, seq_out: head.seq,
                                         stamp_out: head.stamp, handle_out: head.handle,
                                         last: (cnt_reg == ntot_reg - 7'd1),
                                         occupancy: occ_reg, expected_next: exp_reg,
                                         received_count: rcv_reg, reordered_count: reo_reg,
                                         dropped_count: drp_reg};
                        wb.valid  = 1'b0;
                        wb.mark   = 1'b0;
                        cnt_next  = cnt_reg + 7'd1;
                        pass_next = pass_reg + PASS_STEP;
                        if (cnt_reg == ntot_reg - 7'd1) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    shift_en  = 1'b1;
                    pass_next = pass_reg + PASS_STEP;
                    if (cand && (!best_vld_reg || key < best_a_reg)) begin
                        best_vld_next = 1'b1;
                        best_a_next   = key;
                    end
                end
                if (shift_en && pass_reg == LAST_POS && state_next == S_EMIT) begin
                    pass_next     = '0;
                    cur_next      = best_a_next;
                    best_vld_next = 1'b0;
                end
            end

            S_STATUS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next     = '{chunk_valid: 1'b0, seq_out: '0, stamp_out: '0,
                                     handle_out: '0, last: 1'b1, occupancy: occ_reg,
                                     expected_next: exp_reg, received_count: rcv_reg,
                                     reordered_count: reo_reg, dropped_count: drp_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and status registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            exp_reg     <= '0;
            now_reg     <= '0;
            rcv_reg     <= '0;
            reo_reg     <= '0;
            drp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            exp_reg     <= exp_next;
            now_reg     <= now_next;
            rcv_reg     <= rcv_next;
            reo_reg     <= reo_next;
            drp_reg     <= drp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers of the scans.
    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        pass_reg     <= pass_next;
        best_vld_reg <= best_vld_next;
        best_a_reg   <= best_a_next;
        best_b_reg   <= best_b_next;
        max_reg      <= max_next;
        found_reg    <= found_next;
        placed_reg   <= placed_next;
        cnt_reg      <= cnt_next;
        ntot_reg     <= ntot_next;
        flush_reg    <= flush_next;
        base_reg     <= base_next;
        cur_reg      <= cur_next;
        out_reg      <= out_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAPACITY_RST;
            tmo_reg <= TIMEOUT_RST;
            lim_reg <= RELEASE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CAPACITY: cap_reg <= cfg_data[6:0];
                REG_TIMEOUT:  tmo_reg <= cfg_data;
                REG_RELEASE:  lim_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/sro_checker.sv @@
module sro_checker #(
    parameter int DEPTH = 64
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input sro_pkg::out_item_t m_data
);
    import sro_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A status-only result always closes its command.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.chunk_valid |-> m_data.last)
        else $error("status result without last");

    // Occupancy never exceeds the store.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.occupancy <= 7'(DEPTH))
        else $error("occupancy above depth");

    // One command is worked on at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

endmodule

bind sequence_reorder_buffer sro_checker #(.DEPTH(DEPTH)) u_sro_checker (.*);
